/* design/sdlps_pkg.sv */
// Shared types and constants for the switch debounce and LED PWM scan core.
package sdlps_pkg;

  // Fixed field widths
  localparam int unsigned SwitchW   = 32;
  localparam int unsigned LedCount  = 32;
  localparam int unsigned LedNumW   = 5;
  localparam int unsigned LedLevelW = 8;
  localparam int unsigned PwmW      = 7;
  localparam int unsigned SampReqW  = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 168;

  // PWM counter wraps to zero after a scan that used this value
  localparam logic [PwmW-1:0] PwmTop = 7'd127;

  // Reset value of the sample count register
  localparam logic [SampReqW-1:0] SampReqReset = 4'd4;

  // Item kinds carried in tuser
  typedef enum logic {
    OpScan   = 1'b0,
    OpSetLed = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSamplesRequired = 2'd0,
    CfgForcedOnLeds    = 2'd1
  } cfg_idx_e;

  // One scan result; packs into tdata with led_bits in the lowest bits
  typedef struct packed {
    logic [LedNumW-1:0] first_changed_index;
    logic               any_released;
    logic               any_pressed;
    logic               any_changed;
    logic [SwitchW-1:0] released_bits;
    logic [SwitchW-1:0] pressed_bits;
    logic [SwitchW-1:0] changed_bits;
    logic [SwitchW-1:0] debounced_bits;
    logic [SwitchW-1:0] led_bits;
  } result_t;

endpackage

/* design/sdlps_out_buf.sv */
// Output register with skid stage for scan results.
module sdlps_out_buf
  import sdlps_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t result_i,
  output logic    space_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = out_valid_q & m_ready_i;

  // Next state of the two stages; push only arrives while the skid is empty
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d = result_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_d       = result_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o   = ~skid_valid_q;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;

endmodule

/* design/switch_debounce_led_pwm_scan_core.sv */
// Throughput: one transaction per cycle while the skid stage is empty; the
// history AND, PWM compares and change encoder all sit in one pass between
// state and the output register, or the skid stage when the output is held.
// A set_led transaction updates one level and gives no result.
// Reset (rst_ni low, asynchronous) clears history, slot, debounced vector,
// PWM counter and LED levels, sets the sample count to 4 and forced LEDs to 0.
module switch_debounce_led_pwm_scan_core
  import sdlps_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT = 4,
  parameter int unsigned MAX_HISTORY    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: switch_bits[31:0], led_number[36:32], led_level[44:37], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: operation
  input  logic                s_axis_tuser,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: led_bits, debounced_bits, changed_bits, pressed_bits, released_bits
  // (32 each), any_changed, any_pressed, any_released, first_changed_index[167:163]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SlotW = $clog2(MAX_HISTORY);
  localparam int unsigned CntW  = $clog2(MAX_HISTORY + 1);
  localparam logic [63:0] MaskWide = (64'd1 << (8 * REGISTER_COUNT)) - 64'd1;
  localparam logic [SwitchW-1:0] ActiveMask = MaskWide[SwitchW-1:0];

  logic [SampReqW-1:0]  samp_req_q;
  logic [SwitchW-1:0]   forced_q;
  logic [SwitchW-1:0]   hist_q [MAX_HISTORY];
  logic [SlotW-1:0]     slot_q, slot_d;
  logic [SwitchW-1:0]   deb_q;
  logic [PwmW-1:0]      pwm_q, pwm_d;
  logic [LedLevelW-1:0] level_q [LedCount];

  logic                 accept, scan_acc, set_acc;
  logic                 space;
  logic [SwitchW-1:0]   sample;
  logic [LedNumW-1:0]   led_num;
  logic [LedLevelW-1:0] led_lvl;
  logic [CntW-1:0]      eff_cnt;
  logic [PwmW-1:0]      pwm_cnt;
  logic [SwitchW-1:0]   pwm_leds;
  logic [SwitchW-1:0]   deb;
  logic [SwitchW-1:0]   changed;
  logic [LedNumW-1:0]   first_idx;
  result_t              res;
  result_t              out_res;

  // Input unpacking
  assign sample  = s_axis_tdata[31:0] & ActiveMask;
  assign led_num = s_axis_tdata[36:32];
  assign led_lvl = s_axis_tdata[44:37];

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign scan_acc = accept & (op_e'(s_axis_tuser) == OpScan);
  assign set_acc  = accept & (op_e'(s_axis_tuser) == OpSetLed);

  // Configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_req_q <= SampReqReset;
      forced_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgSamplesRequired: samp_req_q <= cfg_data_i[SampReqW-1:0];
        CfgForcedOnLeds:    forced_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sample count clamped to 1..MAX_HISTORY; compare at full width
  always_comb begin
    if (samp_req_q == '0) begin
      eff_cnt = CntW'(1);
    end else if (32'(samp_req_q) > MAX_HISTORY) begin
      eff_cnt = CntW'(MAX_HISTORY);
    end else begin
      eff_cnt = CntW'(samp_req_q);
    end
  end

  // PWM: advance first, then compare every LED level
  assign pwm_cnt = pwm_q + PwmW'(1);
  assign pwm_d   = (pwm_cnt == PwmTop) ? '0 : pwm_cnt;

  always_comb begin
    for (int i = 0; i < LedCount; i++) begin
      pwm_leds[i] = {1'b0, pwm_cnt} < level_q[i];
    end
  end

  // Debounce: AND over the first entries, with the new sample in its slot
  always_comb begin
    deb = '1;
    for (int i = 0; i < MAX_HISTORY; i++) begin
      if (CntW'(i) < eff_cnt) begin
        deb = deb & ((slot_q == SlotW'(i)) ? sample : hist_q[i]);
      end
    end
    deb = deb & ActiveMask;
  end

  assign slot_d  = ((CntW'(slot_q) + CntW'(1)) >= eff_cnt) ? '0 : SlotW'(slot_q + SlotW'(1));
  assign changed = deb ^ deb_q;

  // Lowest changed index, zero when nothing changed
  always_comb begin
    first_idx = '0;
    for (int i = SwitchW - 1; i >= 0; i--) begin
      if (changed[i]) begin
        first_idx = LedNumW'(i);
      end
    end
  end

  // Result assembly
  always_comb begin
    res.led_bits            = (pwm_leds | forced_q) & ActiveMask;
    res.debounced_bits      = deb;
    res.changed_bits        = changed;
    res.pressed_bits        = changed & deb;
    res.released_bits       = changed & ~deb;
    res.any_changed         = |changed;
    res.any_pressed         = |(changed & deb);
    res.any_released        = |(changed & ~deb);
    res.first_changed_index = first_idx;
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      deb_q  <= '0;
      pwm_q  <= '0;
      for (int i = 0; i < MAX_HISTORY; i++) begin
        hist_q[i] <= '0;
      end
    end else if (scan_acc) begin
      slot_q <= slot_d;
      deb_q  <= deb;
      pwm_q  <= pwm_d;
      for (int i = 0; i < MAX_HISTORY; i++) begin
        if (slot_q == SlotW'(i)) begin
          hist_q[i] <= sample;
        end
      end
    end
  end

  // LED levels; LEDs beyond the fitted registers are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LedCount; i++) begin
        level_q[i] <= '0;
      end
    end else if (set_acc && ActiveMask[led_num]) begin
      level_q[led_num] <= led_lvl;
    end
  end

  // Output register and skid stage
  sdlps_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (scan_acc),
    .result_i  (res),
    .space_o   (space),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (out_res)
  );

  assign s_axis_tready = space;
  assign m_axis_tdata  = out_res;

endmodule

/* design/sdlps_checker.sv */
// Port-level checks for the scan core, bound to the top level.
module sdlps_checker
  import sdlps_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tuser,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A scan into an empty output shows up next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OpScan) && !m_axis_tvalid
    |=> m_axis_tvalid)
    else $error("scan result missing");

  // Back-pressure on the input only when the output stage is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // Pressed and released split the changed vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[127:96] & m_axis_tdata[159:128]) == '0)
                   && ((m_axis_tdata[127:96] | m_axis_tdata[159:128])
                       == m_axis_tdata[95:64]))
    else $error("pressed/released inconsistent");

  // Change flag tracks the changed vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[160] == (|m_axis_tdata[95:64])))
    else $error("any_changed inconsistent");

endmodule

bind switch_debounce_led_pwm_scan_core sdlps_checker u_sdlps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
